// ===== hw/rtl/quoted_argument_tokenizer_core_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef QUOTED_ARGUMENT_TOKENIZER_CORE_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_CORE_ASSERT_SVH

// Checked at every rising edge while reset is released.
`define QAT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qat assertion failed");

// Checked at every rising edge, also during reset.
`define QAT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("qat assertion failed");

`endif

// ===== hw/rtl/qat_pkg.sv =====
`timescale 1ns / 1ps

package qat_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_QUOTE    = 3'd1,
    ST_UNCLOSED     = 3'd2,
    ST_DANGLING_ESC = 3'd3,
    ST_TOO_MANY     = 3'd4,
    ST_TOO_LONG     = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       end_of_line;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [4:0] arg_index;
    logic [5:0] char_index;
    status_e    status;
    logic       last_of_run;
  } result_t;

  // All results caused by one request, in order, with their count.
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [2:0]               count;
  } batch_t;

endpackage

// ===== hw/rtl/qat_if.sv =====
`timescale 1ns / 1ps

interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       end_of_line;

  modport source (output valid, output byte_value, output byte_present,
                  output end_of_line, input ready);
  modport sink   (input valid, input byte_value, input byte_present,
                  input end_of_line, output ready);
endinterface

interface qat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [4:0] arg_index;
  logic [5:0] char_index;
  logic [2:0] status;
  logic       last_of_run;

  modport source (output valid, output kind, output value, output arg_index,
                  output char_index, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input value, input arg_index,
                  input char_index, input status, input last_of_run,
                  output ready);
endinterface

// ===== hw/rtl/quoted_argument_tokenizer_core.sv =====
`timescale 1ns / 1ps
// Shell-style argument splitter. Bytes of a command line come in on in_i,
// one per request: byte_value with byte_present set, and end_of_line on the
// final request of the line (it may carry no byte). Results leave on out_o:
// token bytes (kind 0) with argument and byte index, token ends (kind 1)
// with the argument length, and one line-done result (kind 2) carrying the
// argument count and the first error of the line. last_of_run marks the
// final result caused by one input request; a request may cause none.
// An accepted request is held in the input register and is processed once
// the output buffer has room; its results are registered in that buffer.
// Throughput: one request per cycle while each causes at most one result and
// out_o is ready; a request that causes more results holds the output until
// they drain, so the result drain port sets the rate (at most three results per request).
// When out_o stalls, one further request is still taken into the input
// register, then in_i.ready drops until the output drains.
// Reset clears all parsing state and drops any pending results; the block
// is ready for a new line right after reset is released.

module quoted_argument_tokenizer_core import qat_pkg::*; #(
  parameter int unsigned MAX_ARGS    = 16,
  parameter int unsigned MAX_ARG_LEN = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qat_in_if.sink    in_i,
  qat_out_if.source out_o
);

  logic   in_vld_q;
  item_t  in_item_q;
  logic   can_load;
  logic   fire;
  batch_t batch;

  assign fire       = in_vld_q && can_load;
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.byte_value   <= in_i.byte_value;
      in_item_q.byte_present <= in_i.byte_present;
      in_item_q.end_of_line  <= in_i.end_of_line;
    end
  end

  qat_step #(
    .MAX_ARGS    (MAX_ARGS),
    .MAX_ARG_LEN (MAX_ARG_LEN)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_item_q),
    .batch_o (batch)
  );

  qat_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .batch_i    (batch),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

// ===== hw/rtl/qat_step.sv =====
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_core_assert.svh"

module qat_step import qat_pkg::*; #(
  parameter int unsigned MAX_ARGS    = 16,
  parameter int unsigned MAX_ARG_LEN = 64
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   fire_i,
  input  item_t  item_i,
  output batch_t batch_o
);

  localparam int unsigned AW = $clog2(MAX_ARGS + 1);
  localparam int unsigned PW = $clog2(MAX_ARG_LEN);

  typedef struct packed {
    logic          push;
    logic [PW-1:0] pos;
    status_e       err;
  } emit_t;

  logic          tok_q, tok_d;
  logic          quo_q, quo_d;
  logic          esc_q, esc_d;
  logic          qbs_q, qbs_d;
  logic          dq_q, dq_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [AW-1:0] cnt_q, cnt_d;
  status_e       err_q, err_d;

  // Decides whether a token byte is reported at the current position.
  function automatic emit_t try_emit(logic [AW-1:0] cnt, logic [PW-1:0] pos,
                                     status_e err);
    emit_t r;
    r.push = 1'b0;
    r.pos  = pos;
    r.err  = err;
    if (cnt < AW'(MAX_ARGS)) begin
      if (pos >= PW'(MAX_ARG_LEN - 1)) begin
        if (err == ST_OK) r.err = ST_TOO_LONG;
      end else begin
        r.push = 1'b1;
        r.pos  = pos + PW'(1);
      end
    end
    return r;
  endfunction

  function automatic result_t byte_res(logic [7:0] v, logic [AW-1:0] cnt,
                                       logic [PW-1:0] pos);
    result_t r;
    r.kind        = KIND_BYTE;
    r.value       = v;
    r.arg_index   = 5'(cnt);
    r.char_index  = 6'(pos);
    r.status      = ST_OK;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic result_t end_res(logic [AW-1:0] cnt, logic [PW-1:0] pos);
    result_t r;
    r.kind        = KIND_END;
    r.value       = '0;
    r.arg_index   = 5'(cnt);
    r.char_index  = 6'(pos);
    r.status      = ST_OK;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0]               c;
    logic [7:0]               quote;
    logic [2:0]               n;
    emit_t                    em;
    result_t [MaxResults-1:0] res;

    tok_d = tok_q;
    quo_d = quo_q;
    esc_d = esc_q;
    qbs_d = qbs_q;
    dq_d  = dq_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    err_d = err_q;
    n     = '0;
    res   = '0;
    c     = item_i.byte_value;
    quote = dq_q ? CH_DQUOTE : CH_SQUOTE;
    em    = '0;

    if (fire_i && item_i.byte_present) begin
      if (qbs_d && c == quote) begin
        // Backslash before the matching quote: the quote becomes literal.
        qbs_d = 1'b0;
        em = try_emit(cnt_d, pos_d, err_d);
        if (em.push) begin
          res[n[1:0]] = byte_res(c, cnt_d, pos_d);
          n = n + 3'd1;
        end
        pos_d = em.pos;
        err_d = em.err;
      end else begin
        if (qbs_d) begin
          qbs_d = 1'b0;
          em = try_emit(cnt_d, pos_d, err_d);
          if (em.push) begin
            res[n[1:0]] = byte_res(CH_BSLASH, cnt_d, pos_d);
            n = n + 3'd1;
          end
          pos_d = em.pos;
          err_d = em.err;
        end
        if (esc_d) begin
          esc_d = 1'b0;
          if (!tok_d) begin
            tok_d = 1'b1;
            pos_d = '0;
            if (cnt_d >= AW'(MAX_ARGS) && err_d == ST_OK) err_d = ST_TOO_MANY;
          end
          em = try_emit(cnt_d, pos_d, err_d);
          if (em.push) begin
            res[n[1:0]] = byte_res(c, cnt_d, pos_d);
            n = n + 3'd1;
          end
          pos_d = em.pos;
          err_d = em.err;
        end else if (quo_d) begin
          if (c == quote) begin
            if (cnt_d < AW'(MAX_ARGS)) begin
              res[n[1:0]] = end_res(cnt_d, pos_d);
              n = n + 3'd1;
              cnt_d = cnt_d + AW'(1);
            end
            tok_d = 1'b0;
            quo_d = 1'b0;
            pos_d = '0;
          end else if (c == CH_BSLASH) begin
            qbs_d = 1'b1;
          end else begin
            em = try_emit(cnt_d, pos_d, err_d);
            if (em.push) begin
              res[n[1:0]] = byte_res(c, cnt_d, pos_d);
              n = n + 3'd1;
            end
            pos_d = em.pos;
            err_d = em.err;
          end
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
          if (tok_d) begin
            if (cnt_d < AW'(MAX_ARGS)) begin
              res[n[1:0]] = end_res(cnt_d, pos_d);
              n = n + 3'd1;
              cnt_d = cnt_d + AW'(1);
            end
            tok_d = 1'b0;
            quo_d = 1'b0;
            pos_d = '0;
          end
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          if (!tok_d) begin
            tok_d = 1'b1;
            pos_d = '0;
            if (cnt_d >= AW'(MAX_ARGS) && err_d == ST_OK) err_d = ST_TOO_MANY;
            quo_d = 1'b1;
            dq_d  = (c == CH_DQUOTE);
          end else if (err_d == ST_OK) begin
            err_d = ST_BAD_QUOTE;
          end
        end else if (c == CH_BSLASH) begin
          esc_d = 1'b1;
        end else begin
          if (!tok_d) begin
            tok_d = 1'b1;
            pos_d = '0;
            if (cnt_d >= AW'(MAX_ARGS) && err_d == ST_OK) err_d = ST_TOO_MANY;
          end
          em = try_emit(cnt_d, pos_d, err_d);
          if (em.push) begin
            res[n[1:0]] = byte_res(c, cnt_d, pos_d);
            n = n + 3'd1;
          end
          pos_d = em.pos;
          err_d = em.err;
        end
      end
    end

    if (fire_i && item_i.end_of_line) begin
      // A quoted backslash still waiting at line end is taken literally.
      if (qbs_d) begin
        qbs_d = 1'b0;
        em = try_emit(cnt_d, pos_d, err_d);
        if (em.push) begin
          res[n[1:0]] = byte_res(CH_BSLASH, cnt_d, pos_d);
          n = n + 3'd1;
        end
        pos_d = em.pos;
        err_d = em.err;
      end
      if (tok_d && !quo_d) begin
        if (cnt_d < AW'(MAX_ARGS)) begin
          res[n[1:0]] = end_res(cnt_d, pos_d);
          n = n + 3'd1;
          cnt_d = cnt_d + AW'(1);
        end
        tok_d = 1'b0;
        pos_d = '0;
      end
      if (quo_d) begin
        if (err_d == ST_OK) err_d = ST_UNCLOSED;
      end else if (esc_d) begin
        if (err_d == ST_OK) err_d = ST_DANGLING_ESC;
      end
      res[n[1:0]].kind        = KIND_DONE;
      res[n[1:0]].value       = '0;
      res[n[1:0]].arg_index   = 5'(cnt_d);
      res[n[1:0]].char_index  = '0;
      res[n[1:0]].status      = err_d;
      res[n[1:0]].last_of_run = 1'b0;
      n = n + 3'd1;
      tok_d = 1'b0;
      quo_d = 1'b0;
      esc_d = 1'b0;
      qbs_d = 1'b0;
      dq_d  = 1'b0;
      pos_d = '0;
      cnt_d = '0;
      err_d = ST_OK;
    end

    if (n != 3'd0) res[2'(n - 3'd1)].last_of_run = 1'b1;
    batch_o.res   = res;
    batch_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      quo_q <= 1'b0;
      esc_q <= 1'b0;
      qbs_q <= 1'b0;
      dq_q  <= 1'b0;
      pos_q <= '0;
      cnt_q <= '0;
      err_q <= ST_OK;
    end else begin
      tok_q <= tok_d;
      quo_q <= quo_d;
      esc_q <= esc_d;
      qbs_q <= qbs_d;
      dq_q  <= dq_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  `QAT_ASSERT(a_line_end_clears, clk_i, rst_ni,
    (fire_i && item_i.end_of_line) |=> (cnt_q == '0 && !tok_q && !quo_q && err_q == ST_OK))
  `QAT_ASSERT(a_quote_implies_token, clk_i, rst_ni, quo_q |-> tok_q)
  `QAT_ASSERT(a_qbs_in_quotes, clk_i, rst_ni, qbs_q |-> quo_q)

endmodule

// ===== hw/rtl/qat_outbuf.sv =====
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_core_assert.svh"

module qat_outbuf import qat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  batch_t           batch_i,
  output logic             can_load_o,
  qat_out_if.source        out_o
);

  result_t [MaxResults-1:0] res_q;
  logic [2:0]               rem_q;
  logic [1:0]               idx_q;
  result_t                  cur;
  logic                     take;

  assign cur        = res_q[idx_q];
  assign take       = out_o.valid && out_o.ready;
  // Room for a new request once the last pending result leaves.
  assign can_load_o = (rem_q == 3'd0) || (rem_q == 3'd1 && out_o.ready);

  assign out_o.valid       = (rem_q != 3'd0);
  assign out_o.kind        = cur.kind;
  assign out_o.value       = cur.value;
  assign out_o.arg_index   = cur.arg_index;
  assign out_o.char_index  = cur.char_index;
  assign out_o.status      = cur.status;
  assign out_o.last_of_run = cur.last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load_i && batch_i.count != 3'd0) begin
      rem_q <= batch_i.count;
      idx_q <= '0;
    end else if (take) begin
      rem_q <= rem_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && batch_i.count != 3'd0) begin
      res_q <= batch_i.res;
    end
  end

  `QAT_ASSERT(a_load_has_room, clk_i, rst_ni, load_i |-> can_load_o)
  `QAT_ASSERT(a_last_marked, clk_i, rst_ni,
    (rem_q == 3'd1) |-> cur.last_of_run)
  `QAT_ASSERT(a_only_last_marked, clk_i, rst_ni,
    (rem_q > 3'd1) |-> !cur.last_of_run)
  `QAT_ASSERT(a_fill_bound, clk_i, rst_ni,
    ({1'b0, idx_q} + rem_q <= 3'd4))

endmodule
